@@ rtl/core/board_init_sequencer_top_defines.svh @@
// ----------------------------------------------------------------------------
// board_init_sequencer_top_defines.svh
// assertion macros used by bis_core of the board init sequencer rtl
// ----------------------------------------------------------------------------
`ifndef BOARD_INIT_SEQUENCER_TOP_DEFINES_SVH
`define BOARD_INIT_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define BIS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("board_init_sequencer assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define BIS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("board_init_sequencer assertion failed");

`else

`define BIS_ASSERT_NOW(label, ante, cons)
`define BIS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/core/bis_pkg.sv @@
// ----------------------------------------------------------------------------
// bis_pkg
// types, codes and small decode functions of the board init sequencer
// ----------------------------------------------------------------------------
package bis_pkg;

	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 2;

	// request kinds
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_START = 1'b1;

	// sequence codes
	localparam logic [1:0] SEQ_NONE   = 2'd0;
	localparam logic [1:0] SEQ_CLOCK  = 2'd1;
	localparam logic [1:0] SEQ_BOARD  = 2'd2;
	localparam logic [1:0] SEQ_UNUSED = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLEAR_WAIT    = 2'd0,
		CFG_WRITE_TIMEOUT = 2'd1,
		CFG_READ_TIMEOUT  = 2'd2,
		CFG_INIT_DISABLED = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE     = 4'd0,
		ST_PRECLEAR = 4'd1,
		ST_CLKCLEAR = 4'd2,
		ST_CLKWRITE = 4'd3,
		ST_CLKREAD  = 4'd4,
		ST_RCUOFF   = 4'd5,
		ST_BRDCLEAR = 4'd6,
		ST_BSYNC    = 4'd7,
		ST_RAD      = 4'd8,
		ST_RCUON    = 4'd9,
		ST_CDO      = 4'd10
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE      = 4'd0,
		CMD_PRECLEAR  = 4'd1,
		CMD_CLEAR     = 4'd2,
		CMD_CLK_CLEAR = 4'd3,
		CMD_CLK_WRITE = 4'd4,
		CMD_CLK_READ  = 4'd5,
		CMD_RCU_OFF   = 4'd6,
		CMD_RCU_ON    = 4'd7,
		CMD_BSYNC     = 4'd8,
		CMD_RAD       = 4'd9,
		CMD_CDO       = 4'd10
	} cmd_t;

	typedef enum logic [2:0] {
		GRP_NONE      = 3'd0,
		GRP_BRD_CLEAR = 3'd1,
		GRP_CLK_CLEAR = 3'd2,
		GRP_CLK_WRITE = 3'd3,
		GRP_CLK_READ  = 3'd4,
		GRP_RCU       = 3'd5,
		GRP_BSYNC     = 3'd6,
		GRP_RAD       = 3'd7
	} group_t;

	typedef struct packed {
		logic [CFG_W-1:0] clear_wait_ticks;
		logic [CFG_W-1:0] write_timeout_ticks;
		logic [CFG_W-1:0] read_timeout_ticks;
		logic             init_disabled;
	} cfg_t;

	typedef struct packed {
		logic       kind;
		logic [1:0] sequence_req;
		logic       all_idle;
		logic       write_pending;
		logic       read_fault;
		logic       even_second;
	} item_t;

	typedef struct packed {
		logic [3:0] command;
		logic [2:0] watched_group;
		logic [3:0] seq_state;
		logic       active;
		logic       retry;
		logic       done_res;
	} result_t;

	// register group watched in each state
	function automatic group_t group_of(input state_t s);
		group_t g;
		unique case (s)
			ST_PRECLEAR: g = GRP_BRD_CLEAR;
			ST_CLKCLEAR: g = GRP_CLK_CLEAR;
			ST_CLKWRITE: g = GRP_CLK_WRITE;
			ST_CLKREAD:  g = GRP_CLK_READ;
			ST_RCUOFF:   g = GRP_RCU;
			ST_BRDCLEAR: g = GRP_BRD_CLEAR;
			ST_BSYNC:    g = GRP_BSYNC;
			ST_RAD:      g = GRP_RAD;
			ST_RCUON:    g = GRP_RCU;
			ST_CDO:      g = GRP_RCU;
			default:     g = GRP_NONE;
		endcase
		return g;
	endfunction

	// command issued when a state is entered
	function automatic cmd_t entry_cmd(input state_t s, input logic even);
		cmd_t c;
		unique case (s)
			ST_PRECLEAR: c = CMD_PRECLEAR;
			ST_CLKCLEAR: c = CMD_CLK_CLEAR;
			ST_CLKWRITE: c = CMD_CLK_WRITE;
			ST_CLKREAD:  c = CMD_CLK_READ;
			ST_RCUOFF:   c = CMD_RCU_OFF;
			ST_BRDCLEAR: c = CMD_CLEAR;
			ST_BSYNC:    c = CMD_BSYNC;
			ST_RAD:      c = CMD_RAD;
			ST_RCUON:    c = even ? CMD_NONE : CMD_RCU_ON;
			ST_CDO:      c = CMD_CDO;
			default:     c = CMD_NONE;
		endcase
		return c;
	endfunction

	// states whose entry restarts the tick count
	function automatic logic entry_clears_count(input state_t s);
		logic r;
		unique case (s)
			ST_PRECLEAR, ST_CLKREAD, ST_RCUOFF, ST_BRDCLEAR,
			ST_BSYNC, ST_RAD, ST_RCUON: r = 1'b1;
			default:                    r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/bis_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bis_cfg_regs
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module bis_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bis_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [bis_pkg::CFG_W-1:0]     cfg_wdata,
	output bis_pkg::cfg_t                 cfg
);

	bis_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clear_wait_ticks    <= 8'd5;
			cfg_q.write_timeout_ticks <= 8'd3;
			cfg_q.read_timeout_ticks  <= 8'd3;
			cfg_q.init_disabled       <= 1'b0;
		end else if (cfg_we) begin
			unique case (bis_pkg::cfg_idx_t'(cfg_idx))
				bis_pkg::CFG_CLEAR_WAIT:    cfg_q.clear_wait_ticks    <= cfg_wdata;
				bis_pkg::CFG_WRITE_TIMEOUT: cfg_q.write_timeout_ticks <= cfg_wdata;
				bis_pkg::CFG_READ_TIMEOUT:  cfg_q.read_timeout_ticks  <= cfg_wdata;
				bis_pkg::CFG_INIT_DISABLED: cfg_q.init_disabled       <= cfg_wdata[0];
				default:                    cfg_q                     <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/bis_core.sv @@
// ----------------------------------------------------------------------------
// bis_core
// sequencer state, next-state logic and result decode for one request
// ----------------------------------------------------------------------------
`include "board_init_sequencer_top_defines.svh"

module bis_core #(
	parameter int COUNT_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  bis_pkg::item_t   item_s1,
	input  bis_pkg::cfg_t    cfg,
	output bis_pkg::result_t res
);

	localparam int CMP_W = (COUNT_BITS > bis_pkg::CFG_W) ? COUNT_BITS : bis_pkg::CFG_W;

	bis_pkg::state_t        state_q, state_d;
	logic [COUNT_BITS-1:0]  count_q, count_d, count_inc;
	logic                   final_q, final_d;
	logic                   wait_odd_q, wait_d;
	logic [1:0]             wanted_q, wanted_d;
	logic                   running_q, running_d;

	logic                   enter_ev, bump_ev, reread_ev, release_ev, retry_ev, done_ev;
	logic                   gt_clear, gt_write, gt_read;
	bis_pkg::cmd_t          command;

	// compares use the count before this request's increment
	assign gt_clear  = CMP_W'(count_q) > CMP_W'(cfg.clear_wait_ticks);
	assign gt_write  = CMP_W'(count_q) > CMP_W'(cfg.write_timeout_ticks);
	assign gt_read   = CMP_W'(count_q) > CMP_W'(cfg.read_timeout_ticks);
	assign count_inc = (count_q == {COUNT_BITS{1'b1}}) ? count_q : count_q + 1'b1;

	// next state
	always_comb begin
		state_d    = state_q;
		final_d    = final_q;
		wait_d     = wait_odd_q;
		wanted_d   = wanted_q;
		running_d  = running_q;
		enter_ev   = 1'b0;
		bump_ev    = 1'b0;
		reread_ev  = 1'b0;
		release_ev = 1'b0;
		retry_ev   = 1'b0;
		done_ev    = 1'b0;
		if (item_s1.kind == bis_pkg::KIND_START) begin
			wanted_d = (item_s1.sequence_req == bis_pkg::SEQ_UNUSED) ?
				bis_pkg::SEQ_NONE : item_s1.sequence_req;
		end else begin
			unique case (state_q)
				bis_pkg::ST_IDLE: begin
					if (!cfg.init_disabled && wanted_q != bis_pkg::SEQ_NONE) begin
						running_d = 1'b1;
						final_d   = 1'b0;
						enter_ev  = 1'b1;
						state_d   = (wanted_q == bis_pkg::SEQ_CLOCK) ?
							bis_pkg::ST_PRECLEAR : bis_pkg::ST_BRDCLEAR;
					end
				end
				bis_pkg::ST_PRECLEAR: begin
					bump_ev = 1'b1;
					if (gt_clear && item_s1.all_idle) begin
						enter_ev = 1'b1;
						state_d  = bis_pkg::ST_CLKCLEAR;
					end
				end
				bis_pkg::ST_CLKCLEAR: begin
					if (item_s1.all_idle) begin
						enter_ev = 1'b1;
						state_d  = bis_pkg::ST_CLKWRITE;
					end
				end
				bis_pkg::ST_CLKWRITE: begin
					if (item_s1.all_idle) begin
						enter_ev = 1'b1;
						state_d  = bis_pkg::ST_CLKREAD;
					end
				end
				bis_pkg::ST_CLKREAD: begin
					if (item_s1.read_fault) begin
						bump_ev = 1'b1;
						if (gt_read) begin
							retry_ev = 1'b1;
							enter_ev = 1'b1;
							state_d  = bis_pkg::ST_CLKWRITE;
						end else begin
							reread_ev = 1'b1;
						end
					end else if (item_s1.all_idle) begin
						enter_ev = 1'b1;
						state_d  = bis_pkg::ST_RCUOFF;
					end
				end
				bis_pkg::ST_RCUOFF: begin
					bump_ev = 1'b1;
					if (gt_write && item_s1.write_pending) begin
						retry_ev = 1'b1;
						final_d  = 1'b0;
						enter_ev = 1'b1;
						state_d  = bis_pkg::ST_CLKCLEAR;
					end else if (item_s1.all_idle) begin
						if (final_q) begin
							state_d   = bis_pkg::ST_IDLE;
							wanted_d  = bis_pkg::SEQ_NONE;
							running_d = 1'b0;
							done_ev   = 1'b1;
						end else begin
							enter_ev = 1'b1;
							state_d  = bis_pkg::ST_BRDCLEAR;
						end
					end
				end
				bis_pkg::ST_BRDCLEAR: begin
					bump_ev = 1'b1;
					if (gt_clear && item_s1.all_idle) begin
						enter_ev = 1'b1;
						state_d  = bis_pkg::ST_BSYNC;
					end
				end
				bis_pkg::ST_BSYNC, bis_pkg::ST_RAD: begin
					bump_ev = 1'b1;
					if (gt_write && item_s1.write_pending) begin
						retry_ev = 1'b1;
						enter_ev = 1'b1;
						state_d  = bis_pkg::ST_BRDCLEAR;
					end else if (item_s1.all_idle) begin
						enter_ev = 1'b1;
						state_d  = (state_q == bis_pkg::ST_BSYNC) ?
							bis_pkg::ST_RAD : bis_pkg::ST_RCUON;
					end
				end
				bis_pkg::ST_RCUON: begin
					if (wait_odd_q) begin
						if (!item_s1.even_second) begin
							wait_d     = 1'b0;
							release_ev = 1'b1;
						end
					end else begin
						bump_ev = 1'b1;
						if (gt_write && item_s1.write_pending) begin
							retry_ev = 1'b1;
							enter_ev = 1'b1;
							state_d  = bis_pkg::ST_BRDCLEAR;
						end else if (item_s1.all_idle) begin
							enter_ev = 1'b1;
							state_d  = bis_pkg::ST_CDO;
						end
					end
				end
				bis_pkg::ST_CDO: begin
					bump_ev = 1'b1;
					if (gt_write && item_s1.write_pending) begin
						retry_ev = 1'b1;
						enter_ev = 1'b1;
						state_d  = bis_pkg::ST_BRDCLEAR;
					end else if (item_s1.all_idle) begin
						final_d  = 1'b1;
						enter_ev = 1'b1;
						state_d  = bis_pkg::ST_RCUOFF;
					end
				end
				default: begin
					state_d = bis_pkg::ST_IDLE;
				end
			endcase
		end

		// entering receiver enable in an even second holds the enable back
		if (enter_ev && state_d == bis_pkg::ST_RCUON) begin
			wait_d = item_s1.even_second;
		end

		if (enter_ev && bis_pkg::entry_clears_count(state_d)) begin
			count_d = '0;
		end else if (bump_ev) begin
			count_d = count_inc;
		end else begin
			count_d = count_q;
		end
	end

	// outputs
	always_comb begin
		command = bis_pkg::CMD_NONE;
		if (enter_ev) begin
			command = bis_pkg::entry_cmd(state_d, item_s1.even_second);
		end else if (reread_ev) begin
			command = bis_pkg::CMD_CLK_READ;
		end else if (release_ev) begin
			command = bis_pkg::CMD_RCU_ON;
		end
		res.command       = command;
		res.watched_group = bis_pkg::group_of(state_d);
		res.seq_state     = state_d;
		res.active        = running_d;
		res.retry         = retry_ev;
		res.done_res      = done_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bis_pkg::ST_IDLE;
			count_q    <= '0;
			final_q    <= 1'b0;
			wait_odd_q <= 1'b0;
			wanted_q   <= bis_pkg::SEQ_NONE;
			running_q  <= 1'b0;
		end else if (step_en) begin
			state_q    <= state_d;
			count_q    <= count_d;
			final_q    <= final_d;
			wait_odd_q <= wait_d;
			wanted_q   <= wanted_d;
			running_q  <= running_d;
		end
	end

	`BIS_ASSERT_NEXT(a_done_to_idle, step_en && done_ev, state_q == bis_pkg::ST_IDLE && !running_q)
	`BIS_ASSERT_NOW(a_retry_not_done, step_en, !(retry_ev && done_ev))
	`BIS_ASSERT_NEXT(a_hold_when_stalled, !step_en, $stable(state_q) && $stable(count_q))
	`BIS_ASSERT_NOW(a_busy_is_running, state_q != bis_pkg::ST_IDLE, running_q)
	`BIS_ASSERT_NOW(a_wait_only_rcuon, wait_odd_q, state_q == bis_pkg::ST_RCUON)

endmodule

@@ rtl/core/board_init_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// board_init_sequencer_top
// board start-up sequencer: start requests and timer ticks in, commands out
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while the result side is not
// stalled and returns exactly one result per request. An accepted request
// waits in the input register until the result register is free or
// emptying, then one step of the sequencer state machine is computed and
// written into the result register. A start request only
// records the wanted sequence (clock set or board clear). A timer tick
// carries the status of the register group currently watched and advances
// the sequence: pre-clear, clock clear, clock write, clock read-back with
// retry, receiver disable, board clear, block-sync write, RAD write,
// receiver enable (held until an odd second), output enable and a final
// receiver disable that ends the sequence with done_res set. Throughput is
// one request per unstalled cycle, set by the single state update per request.
// While a result waits unaccepted the input register can still take one more
// request; after that item_ready stays low until the result is taken.
// Configuration registers are written through cfg_we/cfg_idx/cfg_wdata and
// must only change while no request is in flight.
module board_init_sequencer_top #(
	parameter int COUNT_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [bis_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [bis_pkg::CFG_W-1:0]     cfg_wdata,
	// request channel
	input  logic                          item_valid,
	output logic                          item_ready,
	input  bis_pkg::item_t                item,
	// result channel
	output logic                          result_valid,
	input  logic                          result_ready,
	output bis_pkg::result_t              result
);

	bis_pkg::cfg_t    cfg;
	bis_pkg::item_t   item_s1;
	logic             valid_s1;
	bis_pkg::result_t res_step;
	bis_pkg::result_t result_q;
	logic             result_valid_q;
	logic             advance;

	// a request steps the sequencer when the result register is free or emptying
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	bis_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// sequencer step
	bis_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item_s1 (item_s1),
		.cfg     (cfg),
		.res     (res_step)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_step;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ sim/tb_board_init_sequencer_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_board_init_sequencer_top
// self-checking bench for the board start-up sequencer
// ----------------------------------------------------------------------------
// A mirror of the sequencer state machine predicts the result of every
// accepted request. Results are compared field by field, in order. The run
// starts with a short scripted walk through a whole clock-set sequence and
// then runs random phases under several register settings. Most random ticks
// carry status that lets the sequence move on, and the rest stall it or are
// noise. Both channels idle at random except in the last phase.
// ----------------------------------------------------------------------------
module tb_board_init_sequencer_top;
	import bis_pkg::*;

	localparam int CNT_W       = 8;     // matches the default COUNT_BITS
	localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all

	// mirror of the sequencer: its own state, its own copy of the registers
	class sequencer_mirror;
		cfg_t             cfg;
		state_t           st;
		logic [CNT_W-1:0] ticks;
		bit               final_pass;
		bit               wait_odd;
		bit               running;
		logic [1:0]       wanted;
		result_t          pending_results[$];
		int               errors, shown, n_checked, n_retry, n_done, n_sat;

		function new();
			cfg.clear_wait_ticks    = 8'd5;
			cfg.write_timeout_ticks = 8'd3;
			cfg.read_timeout_ticks  = 8'd3;
			cfg.init_disabled       = 1'b0;
			st         = ST_IDLE;
			ticks      = '0;
			final_pass = 0;
			wait_odd   = 0;
			running    = 0;
			wanted     = SEQ_NONE;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
			case (idx)
				CFG_CLEAR_WAIT:    cfg.clear_wait_ticks = v;
				CFG_WRITE_TIMEOUT: cfg.write_timeout_ticks = v;
				CFG_READ_TIMEOUT:  cfg.read_timeout_ticks = v;
				CFG_INIT_DISABLED: cfg.init_disabled = v[0];
			endcase
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function bit at_rest();
			return st == ST_IDLE && wanted == SEQ_NONE;
		endfunction

		// count before the increment, saturating
		function logic [CNT_W-1:0] bump();
			logic [CNT_W-1:0] old;
			old = ticks;
			if (ticks != '1)
				ticks++;
			else
				n_sat++;
			return old;
		endfunction

		function group_t watched(state_t s);
			case (s)
				ST_PRECLEAR, ST_BRDCLEAR:     return GRP_BRD_CLEAR;
				ST_CLKCLEAR:                  return GRP_CLK_CLEAR;
				ST_CLKWRITE:                  return GRP_CLK_WRITE;
				ST_CLKREAD:                   return GRP_CLK_READ;
				ST_RCUOFF, ST_RCUON, ST_CDO:  return GRP_RCU;
				ST_BSYNC:                     return GRP_BSYNC;
				ST_RAD:                       return GRP_RAD;
				default:                      return GRP_NONE;
			endcase
		endfunction

		// move to a state, returning the command sent on the way in
		function cmd_t go(state_t s, logic even);
			cmd_t c;
			st = s;
			case (s)
				ST_PRECLEAR: begin ticks = '0; c = CMD_PRECLEAR; end
				ST_CLKCLEAR: c = CMD_CLK_CLEAR;
				ST_CLKWRITE: c = CMD_CLK_WRITE;
				ST_CLKREAD:  begin ticks = '0; c = CMD_CLK_READ; end
				ST_RCUOFF:   begin ticks = '0; c = CMD_RCU_OFF; end
				ST_BRDCLEAR: begin ticks = '0; c = CMD_CLEAR; end
				ST_BSYNC:    begin ticks = '0; c = CMD_BSYNC; end
				ST_RAD:      begin ticks = '0; c = CMD_RAD; end
				ST_RCUON: begin
					ticks    = '0;
					wait_odd = even;
					c = even ? CMD_NONE : CMD_RCU_ON;
				end
				ST_CDO:      c = CMD_CDO;
				default:     c = CMD_NONE;
			endcase
			return c;
		endfunction

		function void note_request(item_t it);
			cmd_t    c;
			bit      rty, fin;
			logic    ev, idle, wp;
			result_t r;
			c    = CMD_NONE;
			rty  = 0;
			fin  = 0;
			ev   = it.even_second;
			idle = it.all_idle;
			wp   = it.write_pending;
			if (it.kind == KIND_START) begin
				wanted = (it.sequence_req == SEQ_UNUSED) ? SEQ_NONE : it.sequence_req;
			end else begin
				case (st)
					ST_IDLE: if (!cfg.init_disabled && wanted != SEQ_NONE) begin
						running    = 1;
						final_pass = 0;
						c = go(wanted == SEQ_CLOCK ? ST_PRECLEAR : ST_BRDCLEAR, ev);
					end
					ST_PRECLEAR:
						if (bump() > cfg.clear_wait_ticks && idle) c = go(ST_CLKCLEAR, ev);
					ST_CLKCLEAR: if (idle) c = go(ST_CLKWRITE, ev);
					ST_CLKWRITE: if (idle) c = go(ST_CLKREAD, ev);
					ST_CLKREAD: begin
						if (it.read_fault) begin
							if (bump() > cfg.read_timeout_ticks) begin
								rty = 1;
								c   = go(ST_CLKWRITE, ev);
							end else begin
								c = CMD_CLK_READ;
							end
						end else if (idle) begin
							c = go(ST_RCUOFF, ev);
						end
					end
					ST_RCUOFF: begin
						if (bump() > cfg.write_timeout_ticks && wp) begin
							rty        = 1;
							final_pass = 0;
							c          = go(ST_CLKCLEAR, ev);
						end else if (idle) begin
							if (final_pass) begin
								st      = ST_IDLE;
								wanted  = SEQ_NONE;
								running = 0;
								fin     = 1;
							end else begin
								c = go(ST_BRDCLEAR, ev);
							end
						end
					end
					ST_BRDCLEAR:
						if (bump() > cfg.clear_wait_ticks && idle) c = go(ST_BSYNC, ev);
					ST_BSYNC, ST_RAD: begin
						if (bump() > cfg.write_timeout_ticks && wp) begin
							rty = 1;
							c   = go(ST_BRDCLEAR, ev);
						end else if (idle) begin
							c = go(st == ST_BSYNC ? ST_RAD : ST_RCUON, ev);
						end
					end
					ST_RCUON: begin
						if (wait_odd) begin
							if (!ev) begin
								wait_odd = 0;
								c        = CMD_RCU_ON;
							end
						end else if (bump() > cfg.write_timeout_ticks && wp) begin
							rty = 1;
							c   = go(ST_BRDCLEAR, ev);
						end else if (idle) begin
							c = go(ST_CDO, ev);
						end
					end
					ST_CDO: begin
						if (bump() > cfg.write_timeout_ticks && wp) begin
							rty = 1;
							c   = go(ST_BRDCLEAR, ev);
						end else if (idle) begin
							final_pass = 1;
							c          = go(ST_RCUOFF, ev);
						end
					end
					default: st = ST_IDLE;
				endcase
			end
			r.command       = c;
			r.watched_group = watched(st);
			r.seq_state     = st;
			r.active        = running;
			r.retry         = rty;
			r.done_res      = fin;
			pending_results.push_back(r);
			n_retry += rty;
			n_done  += fin;
		endfunction

		function void check_result(result_t got);
			result_t want;
			bit      bad;
			n_checked++;
			if (pending_results.size() == 0) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("result with nothing expected: cmd %0d state %0d",
						got.command, got.seq_state);
				end
				return;
			end
			want = pending_results.pop_front();
			bad = (got.command !== want.command) || (got.watched_group !== want.watched_group)
				|| (got.seq_state !== want.seq_state) || (got.active !== want.active)
				|| (got.retry !== want.retry) || (got.done_res !== want.done_res);
			if (bad) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("result %0d: expected cmd %0d grp %0d st %0d act %b rty %b done %b",
						n_checked, want.command, want.watched_group, want.seq_state,
						want.active, want.retry, want.done_res);
					$display("            got      cmd %0d grp %0d st %0d act %b rty %b done %b",
						got.command, got.watched_group, got.seq_state,
						got.active, got.retry, got.done_res);
				end
			end
		endfunction
	endclass

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx      = '0;
	logic [CFG_W-1:0]     cfg_wdata    = '0;
	logic                 item_valid   = 1'b0;
	logic                 item_ready;
	item_t                item         = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result;

	sequencer_mirror sb;

	// idling knobs, changed per phase
	int gap_pct   = 0;
	int stall_pct = 0;
	bit calm      = 0;
	int mood      = 0;   // 0..5 cooperative status, 6..7 stubborn, 8..9 noise
	int n_requests = 0;
	int n_settings = 1;  // reset values count as the first setting

	board_init_sequencer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// result side: check every accepted result, then decide on a stall burst
	int stall_left = 0;
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
		if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (!calm && $urandom_range(99) < stall_pct) begin
			stall_left = $urandom_range(10, 1) - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// watchdog: no request and no result moving for too long ends the run
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	// one request: optional gap with valid low, then hold it until accepted
	task automatic push_request(item_t it);
		if (!calm && $urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(10, 1)) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		sb.note_request(it);
		n_requests++;
	endtask

	task automatic tick(int idle, int wp, int rerr, int even);
		item_t it;
		it.kind          = KIND_TICK;
		it.sequence_req  = 2'($urandom_range(3));
		it.all_idle      = 1'(idle);
		it.write_pending = 1'(wp);
		it.read_fault    = 1'(rerr);
		it.even_second   = 1'(even);
		push_request(it);
	endtask

	task automatic start(logic [1:0] sq);
		item_t it;
		it              = item_t'(7'($urandom_range(127)));
		it.kind         = KIND_START;
		it.sequence_req = sq;
		push_request(it);
	endtask

	// stop sending and wait until every expected result is back
	task automatic settle();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(cfg_idx_t idx, logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= v;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic load_config(logic [7:0] cw, logic [7:0] wt, logic [7:0] rt, logic dis);
		settle();
		reg_write(CFG_CLEAR_WAIT, cw);
		reg_write(CFG_WRITE_TIMEOUT, wt);
		reg_write(CFG_READ_TIMEOUT, rt);
		reg_write(CFG_INIT_DISABLED, {7'd0, dis});
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// next random request, shaped by where the mirror says the sequencer is
	function automatic item_t make_item();
		item_t it;
		it = item_t'(7'($urandom_range(127)));
		if ($urandom_range(29) == 0)
			mood = $urandom_range(9);
		// at rest: half the time ask for a sequence so the run gets going again
		if (sb.at_rest() && $urandom_range(1) == 1) begin
			it.kind         = KIND_START;
			it.sequence_req = $urandom_range(1) ? SEQ_CLOCK : SEQ_BOARD;
			return it;
		end
		// occasional stray start request with any code, even mid-sequence
		if ($urandom_range(99) < 3) begin
			it.kind = KIND_START;
			return it;
		end
		it.kind = KIND_TICK;
		if (mood < 6) begin
			// cooperative: groups idle, rare leftover write or read error
			it.all_idle      = 1'b1;
			it.write_pending = ($urandom_range(19) == 0);
			it.read_fault    = ($urandom_range(19) == 0);
		end else if (mood < 8) begin
			// stubborn: writes stay pending and reads fail, drives the timeouts
			it.write_pending = 1'b1;
			it.read_fault    = 1'b1;
		end
		return it;
	endfunction

	task automatic run_random(int n);
		repeat (n) push_request(make_item());
	endtask

	task automatic random_phase(int n, logic dis);
		load_config(8'($urandom_range(7)), 8'($urandom_range(5)), 8'($urandom_range(5)), dis);
		gap_pct   = $urandom_range(2) == 0 ? 0 : $urandom_range(40, 5);
		stall_pct = $urandom_range(2) == 0 ? 0 : $urandom_range(40, 5);
		run_random(n);
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct   = 15;
		stall_pct = 15;

		// reset values: unused code is stored as none, so the tick does nothing
		start(SEQ_UNUSED);
		tick(1, 1, 1, 1);

		// zero timeouts: scripted clock-set sequence through every state
		load_config(8'd0, 8'd0, 8'd0, 1'b0);
		start(SEQ_CLOCK);
		tick(1, 0, 0, 0);   // idle -> pre-clear
		tick(1, 0, 0, 0);   // count not above limit yet
		tick(1, 1, 1, 0);   // contradictory bits, idle wins here
		tick(1, 0, 0, 0);   // clock clear -> clock write
		tick(1, 0, 0, 0);   // -> clock read
		tick(1, 0, 1, 0);   // read error before timeout: read again
		tick(0, 0, 1, 0);   // read error after timeout: clock write, retry
		tick(1, 0, 0, 0);   // -> clock read
		tick(1, 0, 0, 0);   // -> receiver disable
		tick(1, 1, 0, 0);   // pending write, no timeout yet, idle wins
		tick(1, 0, 0, 0);   // board clear waiting
		tick(1, 0, 0, 0);   // -> block-sync
		tick(1, 0, 0, 0);   // -> rad
		tick(0, 1, 0, 0);   // pending, under timeout
		tick(1, 1, 0, 1);   // pending after timeout: back to board clear
		tick(1, 0, 0, 0);
		tick(1, 0, 0, 0);   // -> block-sync
		tick(1, 0, 0, 0);   // -> rad
		tick(1, 0, 0, 1);   // -> receiver enable in an even second, held back
		tick(1, 0, 0, 1);   // still even
		tick(1, 0, 0, 0);   // odd second: receiver on
		tick(1, 0, 0, 0);   // -> output enable
		tick(1, 0, 0, 0);   // -> final receiver disable
		tick(1, 0, 0, 0);   // sequence done

		// random phases
		load_config(8'd0, 8'd0, 8'd0, 1'b0);
		run_random(200);
		// largest limits: clears never finish and the count saturates
		load_config(8'd255, 8'd255, 8'd255, 1'b0);
		run_random(320);
		random_phase(120, 1'b1);
		random_phase(220, 1'b0);
		random_phase(220, 1'b0);
		random_phase(220, 1'b0);

		// last stretch: both sides run flat out
		calm = 1;
		random_phase(150, 1'b0);

		settle();
		repeat (8) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0d expected results never arrived", sb.pending());
			sb.errors += sb.pending();
		end
		$display("covered %0d requests and %0d results over %0d register settings",
			n_requests, sb.n_checked, n_settings);
		$display("%0d retries, %0d finished sequences, %0d ticks at full count, %0d errors",
			sb.n_retry, sb.n_done, sb.n_sat, sb.errors);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/bis_pkg.sv
rtl/core/bis_cfg_regs.sv
rtl/core/bis_core.sv
rtl/core/board_init_sequencer_top.sv
sim/tb_board_init_sequencer_top.sv
